/* sv/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants for the wildcard byte pattern search
// Word layout widths, request codes and the result record.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 256;
  localparam int unsigned BUFFER_MAX_DEF  = 65536;

  localparam int unsigned LEN_W     = 9;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFS_W     = 16;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [OFS_W-1:0] OFS_SAT = '1;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_DATA = 1'b1
  } req_e;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] match_offset;
  } res_t;

endpackage

/* sv/wbps_cell.sv */
// ----------------------------------------------------------------------------
// wbps_cell: one pattern position of the search chain
// Holds the expected byte, the wildcard mark and the partial-match bit.
// ----------------------------------------------------------------------------
module wbps_cell import wbps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [BYTE_W-1:0] wr_byte_i,
  input  logic              wr_wild_i,
  input  logic              step_i,
  input  logic              prev_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              pm_o
);

  logic [BYTE_W-1:0] pat_q;
  logic              wild_q;
  logic              pm_q, pm_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pat_q  <= wr_byte_i;
      wild_q <= wr_wild_i;
    end
  end

  always_comb begin
    pm_d = pm_q;
    if (step_i) begin
      pm_d = prev_i & (wild_q | (pat_q == data_byte_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= 1'b0;
    end else begin
      pm_q <= pm_d;
    end
  end

  assign pm_o = pm_q;

endmodule

/* sv/wbps_ofifo.sv */
// ----------------------------------------------------------------------------
// wbps_ofifo: two-word result buffer
// Decouples the match stage from the output stream.
// ----------------------------------------------------------------------------
module wbps_ofifo import wbps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  res_t       data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output res_t       data_o,
  output logic [1:0] count_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

/* sv/wildcard_byte_pattern_search.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search: leftmost wildcard pattern match in a byte stream
// Pattern loads and data bytes share the input stream; one result per buffer.
// ----------------------------------------------------------------------------
// One input word is taken every clock (load or data byte). Each data byte is
// compared against all PATTERN_MAX pattern positions at once by a row of
// cells whose partial-match bits shift one cell per byte; in the next cycle a
// registered match stage picks the bit at position pattern_length-1 and keeps
// the leftmost hit. The result for a buffer is formed in the match stage after
// its last byte and written into a two-word output buffer, so input stalls
// only when that buffer and the match stage together already hold two pending
// results and the output is not draining. Bytes at offset BUFFER_MAX and
// beyond only count toward the end of the buffer.
module wildcard_byte_pattern_search import wbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned BUFFER_MAX  = BUFFER_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LEN_W-1:0]      cfg_wdata_i,    // pattern_length
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] pat_index, [15:8] pat_byte, [16] pat_wild, [24:17] data_byte
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,   // req_type
  input  logic                  s_axis_tlast,   // data_last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] found, [16:1] match_offset
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(BUFFER_MAX + 1);

  logic [IDX_W-1:0]  pat_index;
  logic [BYTE_W-1:0] pat_byte;
  logic              pat_wild;
  logic [BYTE_W-1:0] data_byte;

  assign pat_index = s_axis_tdata[7:0];
  assign pat_byte  = s_axis_tdata[15:8];
  assign pat_wild  = s_axis_tdata[16];
  assign data_byte = s_axis_tdata[24:17];

  logic in_acc, load_acc, data_acc, step;

  logic [LEN_W-1:0] len_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             clr_q, clr_d;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign load_acc = in_acc & (req_e'(s_axis_tuser) == REQ_LOAD);
  assign data_acc = in_acc & (req_e'(s_axis_tuser) == REQ_DATA);
  assign step     = data_acc & (cnt_q < CNT_W'(BUFFER_MAX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // cell chain
  logic [PATTERN_MAX-1:0] pm;
  logic [PATTERN_MAX-1:0] tap;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      // first byte of a new buffer starts from an empty chain
      assign prev = pm[k-1] & ~clr_q;
    end

    wbps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (load_acc && (int'(pat_index) == k)),
      .wr_byte_i  (pat_byte),
      .wr_wild_i  (pat_wild),
      .step_i     (step),
      .prev_i     (prev),
      .data_byte_i(data_byte),
      .pm_o       (pm[k])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    clr_d = clr_q;
    if (data_acc) begin
      clr_d = s_axis_tlast;
      if (s_axis_tlast) begin
        cnt_d = '0;
      end else if (step) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      clr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      clr_q <= clr_d;
    end
  end

  // match stage
  logic             s1_valid_q, s1_cmp_q, s1_last_q;
  logic [CNT_W-1:0] s1_cnt_q;
  logic [LEN_W-1:0] s1_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cmp_q   <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= data_acc;
      s1_cmp_q   <= step;
      s1_last_q  <= data_acc & s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      s1_cnt_q <= cnt_q;
      s1_len_q <= len_q;
    end
  end

  logic [LEN_W-1:0] len_m1;
  assign len_m1 = s1_len_q - LEN_W'(1);

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_tap
    assign tap[k] = pm[k] & (int'(len_m1) == k);
  end

  logic             hit_seen_q, hit_seen_d;
  logic [OFS_W-1:0] hit_ofs_q, hit_ofs_d;
  logic             hit_now;
  logic [31:0]      start_w;
  logic [OFS_W-1:0] start_sat;
  logic             push;
  res_t             push_res;

  assign hit_now = s1_valid_q & s1_cmp_q & ~hit_seen_q & (s1_len_q != '0) & (|tap);
  assign start_w   = 32'(s1_cnt_q) + 32'd1 - 32'(s1_len_q);
  assign start_sat = (start_w > 32'(OFS_SAT)) ? OFS_SAT : start_w[OFS_W-1:0];

  always_comb begin
    hit_seen_d = hit_seen_q;
    hit_ofs_d  = hit_ofs_q;
    push       = 1'b0;
    push_res   = '0;
    if (s1_valid_q && s1_last_q) begin
      push                  = 1'b1;
      push_res.found        = hit_seen_q | hit_now;
      push_res.match_offset = hit_seen_q ? hit_ofs_q : (hit_now ? start_sat : '0);
      hit_seen_d            = 1'b0;
      hit_ofs_d             = '0;
    end else if (hit_now) begin
      hit_seen_d = 1'b1;
      hit_ofs_d  = start_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_seen_q <= 1'b0;
      hit_ofs_q  <= '0;
    end else begin
      hit_seen_q <= hit_seen_d;
      hit_ofs_q  <= hit_ofs_d;
    end
  end

  // output buffer
  logic       pop;
  logic [1:0] fifo_cnt;
  logic [2:0] occ;
  res_t       out_res;

  wbps_ofifo u_ofifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_res),
    .pop_i  (pop),
    .valid_o(m_axis_tvalid),
    .data_o (out_res),
    .count_o(fifo_cnt)
  );

  assign pop = m_axis_tvalid & m_axis_tready;
  assign occ = 3'(fifo_cnt) + 3'(s1_valid_q & s1_last_q) - 3'(pop);
  assign s_axis_tready = (occ < 3'd2);

  assign m_axis_tdata = {(OUT_DATA_W - OFS_W - 1)'(0), out_res.match_offset, out_res.found};

endmodule

/* verif/tb_wildcard_byte_pattern_search.sv */
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_search: self-checking bench for the pattern search
// Drives pattern loads and data buffers with random gaps and output stalls,
// and checks each result word against a cycle-free model or a table entry.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_search;
  import wbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAT_DEPTH    = PATTERN_MAX_DEF;
  localparam int unsigned BUF_LIMIT    = BUFFER_MAX_DEF;
  localparam int unsigned SETTLE_CYC   = 4;
  localparam int unsigned DRAIN_CYC    = 8;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_WORDS = 1100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [LEN_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  wildcard_byte_pattern_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // search model state
  bit   [BYTE_W-1:0] srch_pat_val  [PAT_DEPTH];
  bit                srch_pat_wild [PAT_DEPTH];
  bit   [PAT_DEPTH-1:0] srch_partial;
  int                srch_count;
  bit                srch_hit;
  bit   [OFS_W-1:0]  srch_hit_ofs;
  int                srch_len;

  res_t search_results_due [$];
  int   failures;
  int   words_sent;
  bit   no_gaps;

  typedef enum logic { ROW_CFG, ROW_WORD } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [8:0]  plen;
    req_e        req;
    logic [7:0]  idx;
    logic [7:0]  pb;
    logic        pw;
    logic [7:0]  db;
    logic        last;
    bit          chk;
    res_t        exp_res;
  } dir_row_t;

  dir_row_t dir_tab [26] = '{
    // reset length 1: entry 0 = FF; load ignores data_byte and last
    '{ROW_WORD, 9'd0, REQ_LOAD, 8'h00, 8'hFF, 1'b0, 8'h5A, 1'b1, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'hFF, 8'h00, 1'b1, 8'hFF, 1'b1, 1'b1, {1'b1, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b1, 1'b1, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h7E, 1'b1, 1'b1, {1'b1, 16'd1}},
    // zero length never matches
    '{ROW_CFG,  9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b1, {1'b0, 16'd0}},
    // pattern FF ?? 00, top index loaded too
    '{ROW_CFG,  9'd3, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_LOAD, 8'h01, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_LOAD, 8'h02, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_LOAD, 8'hFF, 8'hAA, 1'b1, 8'h00, 1'b1, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h12, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h34, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, {1'b1, 16'd1}},
    // buffer shorter than the pattern
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, {1'b0, 16'd0}},
    // pattern entry rewritten in the middle of a buffer
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_LOAD, 8'h02, 8'h55, 1'b0, 8'h00, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h01, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h55, 1'b1, 1'b0, {1'b0, 16'd0}},
    '{ROW_CFG,  9'd2, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, {1'b0, 16'd0}},
    '{ROW_WORD, 9'd0, REQ_DATA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, {1'b0, 16'd0}}
  };

  // Advance the search model by one accepted word.
  task automatic scan_word(input req_e req, input logic [7:0] idx, input logic [7:0] pb,
                           input logic pw, input logic [7:0] db, input logic last,
                           output bit done, output res_t res);
    bit [PAT_DEPTH-1:0] nxt;
    int                 start;
    done = 1'b0;
    res  = '0;
    if (req == REQ_LOAD) begin
      srch_pat_val[idx]  = pb;
      srch_pat_wild[idx] = pw;
    end else begin
      if (srch_count < BUF_LIMIT) begin
        for (int k = 0; k < PAT_DEPTH; k++) begin
          nxt[k] = (k == 0 ? 1'b1 : srch_partial[k-1]) &
                   (srch_pat_wild[k] | (srch_pat_val[k] == db));
        end
        srch_partial = nxt;
        if (!srch_hit && srch_len >= 1 && srch_len <= PAT_DEPTH &&
            srch_partial[srch_len-1]) begin
          start        = srch_count + 1 - srch_len;
          srch_hit     = 1'b1;
          srch_hit_ofs = (start > 65535) ? OFS_SAT : start[OFS_W-1:0];
        end
        srch_count++;
      end
      if (last) begin
        done             = 1'b1;
        res.found        = srch_hit;
        res.match_offset = srch_hit ? srch_hit_ofs : '0;
        srch_partial     = '0;
        srch_count       = 0;
        srch_hit         = 1'b0;
        srch_hit_ofs     = '0;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_word(input req_e req, input logic [7:0] idx, input logic [7:0] pb,
                           input logic pw, input logic [7:0] db, input logic last,
                           input bit typed = 1'b0, input res_t typed_res = '0);
    int   gap;
    bit   done;
    res_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {7'd0, db, pw, pb, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    scan_word(req, idx, pb, pw, db, last, done, res);
    if (done) search_results_due = {search_results_due, (typed ? typed_res : res)};
    words_sent++;
    @(negedge clk_i);
  endtask

  // Length changes only once the block has drained.
  task automatic set_length(input logic [8:0] plen);
    s_axis_tvalid <= 1'b0;
    while (search_results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= plen;
    @(posedge clk_i);
    srch_len = int'(plen);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [8:0] plen, input int nbufs);
    int         n;
    int         blen;
    int         at;
    bit         embed;
    bit         narrow;
    logic [7:0] db;
    set_length(plen);
    n = (int'(plen) > int'(PAT_DEPTH)) ? int'(PAT_DEPTH) : int'(plen);
    for (int k = 0; k < n; k++) begin
      send_word(REQ_LOAD, 8'(k), 8'($urandom), $urandom_range(99) < (n >= 64 ? 85 : 25),
                8'($urandom), 1'($urandom));
    end
    for (int b = 0; b < nbufs; b++) begin
      blen   = ($urandom_range(9) == 0) ? $urandom_range(3 * n + 40, 1)
                                        : $urandom_range(n + 12, 1);
      embed  = (n > 0) && (n <= blen) && ($urandom_range(9) < 7);
      at     = embed ? $urandom_range(blen - n, 0) : 0;
      narrow = 1'($urandom_range(1));
      for (int k = 0; k < blen; k++) begin
        // stray pattern writes inside a buffer
        if ($urandom_range(99) < 3)
          send_word(REQ_LOAD, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                    1'($urandom));
        if (embed && k >= at && k < at + n && !srch_pat_wild[k-at])
          db = srch_pat_val[k-at];
        else
          db = narrow ? 8'($urandom_range(3)) : 8'($urandom);
        send_word(REQ_DATA, 8'($urandom), 8'($urandom), 1'($urandom), db, k == blen - 1);
      end
    end
  endtask

  // result side: ready with random stalls and long stall-free stretches
  initial begin : result_drain
    int run;
    int hold;
    int r;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(99);
      if (r < 10) begin
        run  = $urandom_range(300, 100);
        hold = 0;
      end else begin
        run  = $urandom_range(8, 1);
        hold = (r < 50) ? 0 : (r < 85) ? $urandom_range(3, 1) :
               (r < 96) ? $urandom_range(15, 4) : $urandom_range(80, 30);
      end
      repeat (run) begin
        m_axis_tready <= 1'b1;
        @(negedge clk_i);
      end
      repeat (hold) begin
        m_axis_tready <= 1'b0;
        @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (search_results_due.size() == 0) begin
        $display("%0t: unexpected result word found=%0b offset=%0d", $realtime,
                 m_axis_tdata[0], m_axis_tdata[16:1]);
        failures++;
      end else begin
        exp_res = search_results_due.pop_front();
        if (m_axis_tdata[0] !== exp_res.found) begin
          $display("%0t: found expected %0b actual %0b", $realtime, exp_res.found,
                   m_axis_tdata[0]);
          failures++;
        end
        if (m_axis_tdata[16:1] !== exp_res.match_offset) begin
          $display("%0t: match_offset expected %0d actual %0d", $realtime,
                   exp_res.match_offset, m_axis_tdata[16:1]);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("tb_wildcard_byte_pattern_search NOT OK");
    $finish;
  end

  initial begin : stimulus
    int         r;
    logic [8:0] plen;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_LOAD;
    s_axis_tlast  = 1'b0;
    failures      = 0;
    words_sent    = 0;
    no_gaps       = 1'b0;
    srch_partial  = '0;
    srch_count    = 0;
    srch_hit      = 1'b0;
    srch_hit_ofs  = '0;
    srch_len      = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG)
        set_length(dir_tab[i].plen);
      else
        send_word(dir_tab[i].req, dir_tab[i].idx, dir_tab[i].pb, dir_tab[i].pw,
                  dir_tab[i].db, dir_tab[i].last, dir_tab[i].chk, dir_tab[i].exp_res);
    end

    // extremes first: full-size pattern, then an out-of-range length
    run_phase(9'd256, 1);
    run_phase(9'd511, 1);
    run_phase(9'd1, 4);
    while (words_sent < RANDOM_WORDS) begin
      no_gaps = ($urandom_range(4) == 0);
      r = $urandom_range(99);
      plen = 9'((r < 10) ? 0 : (r < 70) ? $urandom_range(6, 1) :
                (r < 93) ? $urandom_range(40, 7) : $urandom_range(256, 200));
      run_phase(plen, $urandom_range(6, 2));
    end
    no_gaps = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (search_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (failures == 0)
      $display("tb_wildcard_byte_pattern_search OK");
    else
      $display("tb_wildcard_byte_pattern_search NOT OK");
    $finish;
  end

endmodule
